@@ design/tcw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, command and register codes, and the structs that run
// between the sequencer, the cell RAM port and the top level.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Cell store depth. Must hold a full 80 x 25 screen, so the row count
    // never has to be trimmed to fit the store.
    localparam int CELLS  = 2048;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CELL_W = 16;
    localparam int LOC_W  = 11;

    localparam logic [6:0] MAX_COLS     = 7'd80;
    localparam logic [4:0] MAX_ROWS     = 5'd25;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] LIGHT_GRAY   = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL = {LIGHT_GRAY, BLANK_CHAR};

    localparam logic [1:0] CMD_PUT = 2'd0;
    localparam logic [1:0] CMD_SET = 2'd1;
    localparam logic [1:0] CMD_CLR = 2'd2;
    localparam logic [1:0] CMD_RD  = 2'd3;

    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_ATTR    = 2'd2;
    localparam logic [1:0] CFG_VISIBLE = 2'd3;

    // Effective screen geometry and the write attribute.
    typedef struct packed {
        logic [6:0]        cols;
        logic [4:0]        rows;
        logic [ADDR_W-1:0] total;
        logic [7:0]        attr;
        logic              visible;
    } t_geom;

    // One access to the cell RAM: a write port and a read port.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // Finished result word, valid for one cycle when fin is high.
    typedef struct packed {
        logic              fin;
        logic [CELL_W-1:0] cell_data;
        logic [6:0]        col;
        logic [4:0]        row;
        logic [LOC_W-1:0]  loc;
        logic              shown;
        logic [7:0]        echo;
        logic              scrolled;
    } t_result;

endpackage
`default_nettype wire

@@ design/text_console_writer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console: cell RAM, cursor, put/set/clear/read commands.
// ----------------------------------------------------------------------------
// Usage:
//   Command words enter on i_in_valid / o_in_ready (cmd, ch, pos_x, pos_y,
//   cell_index). Each command returns exactly one result word on
//   o_out_valid / i_out_ready, held in an output register until taken.
//   Geometry, attribute and cursor visibility are written on the cfg
//   channel (i_cfg_valid / o_cfg_ready), which is always ready.
//   One command is in flight at a time; the sequencer owns the single
//   write and single read port of the cell RAM.
//   Put without scroll, set cursor and read go from accept straight to the
//   finish state (the read uses the RAM's registered read data).
//   Clear writes one blank per cycle over all cols*rows cells. A put that
//   scrolls runs a copy loop of one read and one write per
//   cycle over cols*(rows-1) cells, then a blank fill of the bottom row.
//   After reset the block runs a clearing pass over all CELLS (2048) cells,
//   writing light-gray blanks; o_in_ready stays low, cfg writes still land.
//   A new command is taken only when the output register is empty or being
//   drained that cycle; a stalled receiver holds the block off after one
//   pending result.
// ----------------------------------------------------------------------------
module text_console_writer_unit
    import tcw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_ch,
    input  wire logic [7:0]  i_pos_x,
    input  wire logic [7:0]  i_pos_y,
    input  wire logic [10:0] i_cell_index,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_cell_data,
    output logic [6:0]       o_col_now,
    output logic [4:0]       o_row_now,
    output logic [10:0]      o_cursor_location,
    output logic             o_cursor_shown,
    output logic [7:0]       o_echo_char,
    output logic             o_scrolled,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    // Configuration registers.
    logic [6:0] r_columns;
    logic [4:0] r_rows;
    logic [7:0] r_attr;
    logic       r_visible;

    t_geom             geom;
    t_mem_req          mem;
    logic [CELL_W-1:0] rdata;
    t_result           res;
    logic              out_free;

    // Output register.
    logic              r_out_valid;
    t_result           r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= MAX_COLS;
            r_rows    <= MAX_ROWS;
            r_attr    <= LIGHT_GRAY;
            r_visible <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COLUMNS: r_columns <= i_cfg_data[6:0];
                CFG_ROWS:    r_rows    <= i_cfg_data[4:0];
                CFG_ATTR:    r_attr    <= i_cfg_data;
                CFG_VISIBLE: r_visible <= i_cfg_data[0];
                default:     r_visible <= r_visible;
            endcase
        end
    end

    // Saturate the geometry into 1..80 columns and 1..25 rows.
    always_comb begin
        geom.cols = r_columns;
        if (r_columns == 7'd0) begin
            geom.cols = 7'd1;
        end else if (r_columns > MAX_COLS) begin
            geom.cols = MAX_COLS;
        end
        geom.rows = r_rows;
        if (r_rows == 5'd0) begin
            geom.rows = 5'd1;
        end else if (r_rows > MAX_ROWS) begin
            geom.rows = MAX_ROWS;
        end
        geom.attr    = r_attr;
        geom.visible = r_visible;
        geom.total   = ADDR_W'({5'd0, geom.cols} * {7'd0, geom.rows});
    end

    // Drain frees the register in the same cycle.
    assign out_free = !r_out_valid || i_out_ready;

    tcw_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (geom),
        .i_out_free   (out_free),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_ch         (i_ch),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_cell_index (i_cell_index),
        .o_mem        (mem),
        .i_rdata      (rdata),
        .o_res        (res)
    );

    tcw_ram #(
        .DEPTH (CELLS),
        .WIDTH (CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    // Hold the result until taken; load when the sequencer finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.fin) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cell_data       = r_out.cell_data;
    assign o_col_now         = r_out.col;
    assign o_row_now         = r_out.row;
    assign o_cursor_location = r_out.loc;
    assign o_cursor_shown    = r_out.shown;
    assign o_echo_char       = r_out.echo;
    assign o_scrolled        = r_out.scrolled;

`ifndef SYNTHESIS
    // One command in flight: no accept directly after an accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("command accepted while another is in flight");

    // A finished result never overwrites one still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.fin |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // Reported cursor stays on a legal screen position.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_col_now < MAX_COLS && o_row_now < MAX_ROWS))
        else $error("cursor outside screen");
`endif

endmodule
`default_nettype wire

@@ design/tcw_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ design/tcw_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_seq
// Command sequencer: cursor update, cell writes, scroll copy, blank fill and
// the power-up clearing pass over the cell RAM.
// ----------------------------------------------------------------------------
module tcw_seq
    import tcw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_geom             i_geom,
    input  wire logic              i_out_free,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_cmd,
    input  wire logic [7:0]        i_ch,
    input  wire logic [7:0]        i_pos_x,
    input  wire logic [7:0]        i_pos_y,
    input  wire logic [10:0]       i_cell_index,
    output t_mem_req               o_mem,
    input  wire logic [CELL_W-1:0] i_rdata,
    output t_result                o_res
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCROLL = 3'd2;
    localparam logic [2:0] S_BLANK  = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_pend_addr, n_pend_addr;
    logic [6:0]        r_col, n_col;
    logic [4:0]        r_row, n_row;
    logic [1:0]        r_cmd, n_cmd;
    logic [7:0]        r_ch, n_ch;
    logic              r_scrolled, n_scrolled;

    logic              accept;
    logic [6:0]        col_cl;
    logic [4:0]        row_cl;
    logic [11:0]       put_prod;
    logic [ADDR_W-1:0] put_idx;
    logic [6:0]        put_col;
    logic [4:0]        put_row;
    logic [6:0]        set_col;
    logic [4:0]        set_row;
    logic [ADDR_W-1:0] keep;
    logic [11:0]       loc_prod;
    logic [CELL_W-1:0] blank;

    assign o_in_ready = (r_state == S_IDLE) && i_out_free;
    assign accept     = o_in_ready && i_in_valid;

    assign col_cl   = (r_col >= i_geom.cols) ? 7'(i_geom.cols - 7'd1) : r_col;
    assign row_cl   = (r_row >= i_geom.rows) ? 5'(i_geom.rows - 5'd1) : r_row;
    assign put_prod = {7'd0, row_cl} * {5'd0, i_geom.cols};
    assign put_idx  = ADDR_W'(put_prod) + ADDR_W'(col_cl);
    assign keep     = i_geom.total - ADDR_W'(i_geom.cols);
    assign blank    = {i_geom.attr, BLANK_CHAR};
    assign loc_prod = {7'd0, r_row} * {5'd0, i_geom.cols} + {5'd0, r_col};

    // Advance the cursor for a put; a newline or a full row wraps to column 0.
    always_comb begin
        put_col = 7'(col_cl + 7'd1);
        put_row = row_cl;
        if (i_ch == NEWLINE_CHAR || put_col == i_geom.cols) begin
            put_col = 7'd0;
            put_row = 5'(row_cl + 5'd1);
        end
    end

    // Clamp the requested position into the screen.
    always_comb begin
        if (i_pos_x[7]) begin
            set_col = 7'd0;
        end else if (i_pos_x[6:0] >= i_geom.cols) begin
            set_col = 7'(i_geom.cols - 7'd1);
        end else begin
            set_col = i_pos_x[6:0];
        end
        if (i_pos_y[7]) begin
            set_row = 5'd0;
        end else if (i_pos_y[6:0] >= {2'd0, i_geom.rows}) begin
            set_row = 5'(i_geom.rows - 5'd1);
        end else begin
            set_row = i_pos_y[4:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_col       = r_col;
        n_row       = r_row;
        n_cmd       = r_cmd;
        n_ch        = r_ch;
        n_scrolled  = r_scrolled;
        o_mem       = '0;
        o_res       = '0;

        case (r_state)
            S_INIT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_ptr;
                o_mem.wdata = RESET_CELL;
                n_ptr       = ADDR_W'(r_ptr + 1'b1);
                if (r_ptr == ADDR_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_cmd      = i_cmd;
                    n_ch       = i_ch;
                    n_scrolled = 1'b0;
                    n_col      = col_cl;
                    n_row      = row_cl;
                    n_ptr      = '0;
                    n_pend     = 1'b0;
                    n_state    = S_FIN;
                    case (i_cmd)
                        CMD_PUT: begin
                            if (i_ch != NEWLINE_CHAR) begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = put_idx;
                                o_mem.wdata = {i_geom.attr, i_ch};
                            end
                            n_col = put_col;
                            n_row = put_row;
                            if (put_row >= i_geom.rows) begin
                                n_row      = 5'(i_geom.rows - 5'd1);
                                n_scrolled = 1'b1;
                                n_state    = S_SCROLL;
                            end
                        end
                        CMD_SET: begin
                            n_col = set_col;
                            n_row = set_row;
                        end
                        CMD_CLR: begin
                            n_state = S_BLANK;
                        end
                        default: begin
                            o_mem.re    = 1'b1;
                            o_mem.raddr = ADDR_W'(i_cell_index);
                        end
                    endcase
                end
            end
            S_SCROLL: begin
                // Read cell ptr+cols, write it to ptr in the following cycle.
                if (r_pend) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_pend_addr;
                    o_mem.wdata = i_rdata;
                end
                if (r_ptr < keep) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = ADDR_W'(r_ptr + ADDR_W'(i_geom.cols));
                    n_pend      = 1'b1;
                    n_pend_addr = r_ptr;
                    n_ptr       = ADDR_W'(r_ptr + 1'b1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_BLANK;
                end
            end
            S_BLANK: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_ptr;
                o_mem.wdata = blank;
                n_ptr       = ADDR_W'(r_ptr + 1'b1);
                if (r_ptr == ADDR_W'(i_geom.total - 1'b1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_res.fin       = 1'b1;
                o_res.cell_data = (r_cmd == CMD_RD) ? i_rdata : '0;
                o_res.col       = r_col;
                o_res.row       = r_row;
                o_res.loc       = LOC_W'(loc_prod);
                o_res.shown     = (r_cmd inside {CMD_PUT, CMD_SET}) && i_geom.visible;
                o_res.echo      = (r_cmd == CMD_PUT) ? r_ch : 8'd0;
                o_res.scrolled  = r_scrolled;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_ptr      <= '0;
            r_pend     <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_scrolled <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ptr      <= n_ptr;
            r_pend     <= n_pend;
            r_col      <= n_col;
            r_row      <= n_row;
            r_scrolled <= n_scrolled;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        r_cmd       <= n_cmd;
        r_ch        <= n_ch;
    end

endmodule
`default_nettype wire

@@ dv/text_console_writer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_unit_tb
// Self-checking bench for the text console. A mirror of the cell store,
// cursor and registers computes every reply word; a checker compares each
// reply field by field. The run covers directed corners, random sessions over
// many screen geometries, a long output hold-off and a final gap-free stream.
// ----------------------------------------------------------------------------
module text_console_writer_unit_tb;
    import tcw_pkg::*;

    localparam int WATCHDOG_LIMIT = 30000;  // reset clear + full scroll, many times over
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASES         = 12;
    localparam int PHASE_WORDS    = 80;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [7:0]        ch;
        logic signed [7:0] pos_x;
        logic signed [7:0] pos_y;
        logic [10:0]       cell_index;
    } console_cmd_t;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [6:0]  col;
        logic [4:0]  row;
        logic [10:0] loc;
        logic        shown;
        logic [7:0]  echo;
        logic        scrolled;
    } console_reply_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_cmd;
    logic [7:0]  i_ch;
    logic [7:0]  i_pos_x;
    logic [7:0]  i_pos_y;
    logic [10:0] i_cell_index;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_cell_data;
    logic [6:0]  o_col_now;
    logic [4:0]  o_row_now;
    logic [10:0] o_cursor_location;
    logic        o_cursor_shown;
    logic [7:0]  o_echo_char;
    logic        o_scrolled;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    text_console_writer_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_ch              (i_ch),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_cell_index      (i_cell_index),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_cell_data       (o_cell_data),
        .o_col_now         (o_col_now),
        .o_row_now         (o_row_now),
        .o_cursor_location (o_cursor_location),
        .o_cursor_shown    (o_cursor_shown),
        .o_echo_char       (o_echo_char),
        .o_scrolled        (o_scrolled),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Mirror of the console: cell store, cursor and register values.
    logic [15:0] cell_mirror [CELLS];
    int          cur_col;
    int          cur_row;
    int          reg_cols;
    int          reg_rows;
    logic [7:0]  reg_attr;
    logic        reg_visible;

    // Reply words still owed by the block, oldest first.
    console_reply_t console_replies [$];

    int  error_count     = 0;
    int  words_sent      = 0;
    int  replies_checked = 0;
    int  scrolls_seen    = 0;
    int  clears_sent     = 0;
    int  settings_done   = 0;
    int  holds_done      = 0;
    int  idle_cycles     = 0;
    bit  gaps_on         = 1'b1;
    bit  stalls_on       = 1'b1;
    bit  hold_requested  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Effective screen size: saturate both registers, then fit the store.
    function automatic void screen_size(output int nc, output int nr);
        nc = reg_cols;
        if (nc < 1) nc = 1;
        if (nc > MAX_COLS) nc = MAX_COLS;
        if (nc > CELLS) nc = CELLS;
        nr = reg_rows;
        if (nr < 1) nr = 1;
        if (nr > MAX_ROWS) nr = MAX_ROWS;
        if (nc * nr > CELLS) nr = CELLS / nc;
    endfunction

    // Apply one command word to the mirror and return the reply it produces.
    function automatic console_reply_t run_console_cmd(input console_cmd_t w);
        console_reply_t res;
        int nc, nr, idx, keep, k, x, y;
        logic [15:0] blank;
        res = '0;
        screen_size(nc, nr);
        blank = {reg_attr, BLANK_CHAR};
        // a geometry change may have left the cursor off screen
        if (cur_col >= nc) cur_col = nc - 1;
        if (cur_row >= nr) cur_row = nr - 1;
        case (w.cmd)
            CMD_PUT: begin
                if (w.ch == NEWLINE_CHAR) begin
                    cur_col = 0;
                    cur_row++;
                end else begin
                    idx = cur_row * nc + cur_col;
                    if (idx < CELLS) cell_mirror[idx] = {reg_attr, w.ch};
                    cur_col++;
                    if (cur_col == nc) begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
                if (cur_row >= nr) begin
                    // shift every row up, blank the bottom one
                    keep = nc * (nr - 1);
                    for (k = 0; k < keep; k++) cell_mirror[k] = cell_mirror[k + nc];
                    for (k = keep; k < nc * nr; k++) cell_mirror[k] = blank;
                    cur_row = nr - 1;
                    res.scrolled = 1'b1;
                    scrolls_seen++;
                end
                res.shown = reg_visible;
                res.echo  = w.ch;
            end
            CMD_SET: begin
                x = w.pos_x;
                y = w.pos_y;
                if (x < 0) x = 0;
                else if (x >= nc) x = nc - 1;
                if (y < 0) y = 0;
                else if (y >= nr) y = nr - 1;
                cur_col = x;
                cur_row = y;
                res.shown = reg_visible;
            end
            CMD_CLR: begin
                for (k = 0; k < nc * nr; k++) cell_mirror[k] = blank;
                clears_sent++;
            end
            default: begin
                if (w.cell_index < CELLS) res.cell_data = cell_mirror[w.cell_index];
            end
        endcase
        res.col = 7'(cur_col);
        res.row = 5'(cur_row);
        res.loc = 11'(cur_row * nc + cur_col);
        return res;
    endfunction

    function automatic console_cmd_t cmd_word(input logic [1:0] cmd, input logic [7:0] ch,
                                              input logic [7:0] x, input logic [7:0] y,
                                              input logic [10:0] idx);
        console_cmd_t w;
        w.cmd        = cmd;
        w.ch         = ch;
        w.pos_x      = x;
        w.pos_y      = y;
        w.cell_index = idx;
        return w;
    endfunction

    // Random word shaped for a screen of nc x nr: mostly in-range positions
    // and on-screen reads, with full-range values mixed in.
    function automatic console_cmd_t random_cmd(input int nc, input int nr);
        console_cmd_t w;
        int unsigned pick;
        int unsigned clear_pct;
        pick      = $urandom_range(0, 99);
        clear_pct = (nc * nr > 400) ? 1 : 5;
        w = cmd_word(CMD_PUT, 8'($urandom_range(0, 255)), 8'($urandom), 8'($urandom),
                     11'($urandom_range(0, 2047)));
        if (pick < 55) begin
            w.cmd = CMD_PUT;
        end else if (pick < 65) begin
            w.cmd = CMD_PUT;
            w.ch  = NEWLINE_CHAR;
        end else if (pick < 80) begin
            w.cmd = CMD_SET;
            if ($urandom_range(0, 2) != 0) begin
                w.pos_x = 8'($urandom_range(0, nc - 1));
                w.pos_y = 8'($urandom_range(0, nr - 1));
            end
        end else if (pick < 80 + clear_pct) begin
            w.cmd = CMD_CLR;
        end else begin
            w.cmd = CMD_RD;
            if ($urandom_range(0, 3) != 0) w.cell_index = 11'($urandom_range(0, nc * nr - 1));
        end
        return w;
    endfunction

    task automatic report_error(input string what, input longint unsigned got,
                                input longint unsigned want);
        error_count++;
        if (error_count <= 40)
            $display("ERROR reply %0d %s: got 0x%0h, want 0x%0h",
                     replies_checked, what, got, want);
    endtask

    task automatic compare_field(input string what, input longint unsigned got,
                                 input longint unsigned want);
        if (got != want) report_error(what, got, want);
    endtask

    // Offer one command word, optionally after a random idle burst. Valid is
    // left high on return so a back-to-back word never toggles it.
    task automatic send_word(input console_cmd_t w);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= w.cmd;
        i_ch         <= w.ch;
        i_pos_x      <= w.pos_x;
        i_pos_y      <= w.pos_y;
        i_cell_index <= w.cell_index;
        do @(posedge i_clk); while (!o_in_ready);
        console_replies.push_back(run_console_cmd(w));
        words_sent++;
    endtask

    // Drop valid and wait until every owed reply has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (console_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_COLUMNS: reg_cols    = val[6:0];
            CFG_ROWS:    reg_rows    = val[4:0];
            CFG_ATTR:    reg_attr    = val;
            CFG_VISIBLE: reg_visible = val[0];
            default: ;
        endcase
    endtask

    // Registers change only with the block idle.
    task automatic apply_config(input logic [7:0] cols, input logic [7:0] rows,
                                input logic [7:0] attr, input logic [7:0] vis);
        settle();
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_ATTR, attr);
        write_reg(CFG_VISIBLE, vis);
        i_cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // Reset contents, every command, field extremes and full-screen scrolls.
    task automatic test_commands();
        send_word(cmd_word(CMD_RD, 8'h00, 8'h00, 8'h00, 11'd0));
        send_word(cmd_word(CMD_RD, 8'h00, 8'h00, 8'h00, 11'd2047));
        send_word(cmd_word(CMD_PUT, 8'h41, 8'h00, 8'h00, 11'd0));
        send_word(cmd_word(CMD_PUT, 8'h00, 8'h00, 8'h00, 11'd0));
        send_word(cmd_word(CMD_PUT, 8'hFF, 8'h00, 8'h00, 11'd0));
        send_word(cmd_word(CMD_PUT, NEWLINE_CHAR, 8'h00, 8'h00, 11'd0));
        send_word(cmd_word(CMD_SET, 8'h00, 8'h80, 8'h80, 11'd0));
        send_word(cmd_word(CMD_SET, 8'h00, 8'h7F, 8'h7F, 11'd0));
        apply_config(8'd80, 8'd25, 8'hFF, 8'd1);
        send_word(cmd_word(CMD_PUT, NEWLINE_CHAR, 8'h00, 8'h00, 11'd0));
        send_word(cmd_word(CMD_SET, 8'h00, 8'd79, 8'd24, 11'd0));
        send_word(cmd_word(CMD_PUT, 8'h5A, 8'h00, 8'h00, 11'd0));
        send_word(cmd_word(CMD_RD, 8'h00, 8'h00, 8'h00, 11'd1840));
        send_word(cmd_word(CMD_CLR, 8'h00, 8'h00, 8'h00, 11'd0));
        send_word(cmd_word(CMD_RD, 8'h00, 8'h00, 8'h00, 11'd5));
        settle();
    endtask

    // Out-of-range geometry and a cursor left off screen by a resize.
    task automatic test_geometry_limits();
        apply_config(8'd0, 8'd0, 8'h1E, 8'd0);
        send_word(cmd_word(CMD_PUT, 8'h78, 8'h00, 8'h00, 11'd0));
        send_word(cmd_word(CMD_PUT, NEWLINE_CHAR, 8'h00, 8'h00, 11'd0));
        send_word(cmd_word(CMD_SET, 8'h00, 8'd5, 8'd5, 11'd0));
        apply_config(8'hFF, 8'hFF, 8'h70, 8'd1);
        send_word(cmd_word(CMD_SET, 8'h00, 8'h7F, 8'h7F, 11'd0));
        apply_config(8'd10, 8'd4, 8'h4E, 8'd1);
        send_word(cmd_word(CMD_PUT, 8'h71, 8'h00, 8'h00, 11'd0));
        send_word(cmd_word(CMD_RD, 8'h00, 8'h00, 8'h00, 11'd29));
        send_word(cmd_word(CMD_RD, 8'h00, 8'h00, 8'h00, 11'd2047));
        send_word(cmd_word(CMD_SET, 8'h00, 8'hFF, 8'd2, 11'd0));
        settle();
    endtask

    // Random sessions, each on a fresh setting; small screens dominate so
    // clears and scrolls stay cheap.
    task automatic test_random_sessions();
        int p, n, nc, nr;
        for (p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 9))
                0: apply_config(8'd80, 8'd25, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 1)));
                1: apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 1)));
                default: apply_config(8'($urandom_range(1, 16)), 8'($urandom_range(1, 8)),
                                      8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 1)));
            endcase
            screen_size(nc, nr);
            for (n = 0; n < PHASE_WORDS; n++) send_word(random_cmd(nc, nr));
        end
        settle();
    endtask

    // Hold the output off for a long stretch while words keep coming, so the
    // result register fills and the input stalls.
    task automatic test_backpressure();
        int n, nc, nr;
        apply_config(8'd6, 8'd3, 8'h2C, 8'd1);
        screen_size(nc, nr);
        hold_requested = 1'b1;
        for (n = 0; n < 40; n++) send_word(random_cmd(nc, nr));
        settle();
    endtask

    // Last part: no idling on either side.
    task automatic test_steady_stream();
        int n, nc, nr;
        apply_config(8'd12, 8'd5, 8'h1F, 8'd0);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        screen_size(nc, nr);
        for (n = 0; n < 200; n++) send_word(random_cmd(nc, nr));
        settle();
    endtask

    // Output side pacing: random stall bursts, plus the long hold on request.
    initial begin : out_pacer
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requested) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_requested = 1'b0;
                holds_done++;
                i_out_ready <= 1'b1;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Match each accepted reply word against the oldest owed one.
    always @(posedge i_clk) begin : reply_check
        console_reply_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (console_replies.size() == 0) begin
                report_error("reply with nothing owed", o_cell_data, 0);
            end else begin
                want = console_replies.pop_front();
                compare_field("cell_data", o_cell_data, want.cell_data);
                compare_field("col_now", o_col_now, want.col);
                compare_field("row_now", o_row_now, want.row);
                compare_field("cursor_location", o_cursor_location, want.loc);
                compare_field("cursor_shown", o_cursor_shown, want.shown);
                compare_field("echo_char", o_echo_char, want.echo);
                compare_field("scrolled", o_scrolled, want.scrolled);
            end
            replies_checked++;
        end
    end

    // Abort when no word moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", idle_cycles);
            $display("text_console_writer_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : run
        int k;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_cmd        <= CMD_PUT;
        i_ch         <= 8'h00;
        i_pos_x      <= 8'h00;
        i_pos_y      <= 8'h00;
        i_cell_index <= 11'd0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_COLUMNS;
        i_cfg_data   <= 8'h00;
        for (k = 0; k < CELLS; k++) cell_mirror[k] = RESET_CELL;
        cur_col     = 0;
        cur_row     = 0;
        reg_cols    = MAX_COLS;
        reg_rows    = MAX_ROWS;
        reg_attr    = LIGHT_GRAY;
        reg_visible = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_commands();
        test_geometry_limits();
        test_random_sessions();
        test_backpressure();
        test_steady_stream();

        // let any stray reply surface before the verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run covered %0d command words with %0d scrolls and %0d clears, %0d settings",
                 words_sent, scrolls_seen, clears_sent, settings_done);
        $display("checked %0d reply words across %0d long output hold-offs, %0d errors",
                 replies_checked, holds_done, error_count);
        if (error_count == 0 && console_replies.size() == 0) begin
            $display("text_console_writer_unit: match");
        end else begin
            $display("text_console_writer_unit: mismatch");
        end
        $finish;
    end

endmodule
